[src/tems_pkg.sv]
package tems_pkg;

  // Item kinds carried in in_tuser
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_GLOBAL  = 2'd1;
  localparam logic [1:0] KIND_DIR     = 2'd2;
  localparam logic [1:0] KIND_NEAREST = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_POINTS      = 3'd0;
  localparam logic [2:0] CFG_SEARCH_GREATEST = 3'd1;
  localparam logic [2:0] CFG_PICKUP_DISTANCE = 3'd2;
  localparam logic [2:0] CFG_SELECTED_TRACE  = 3'd3;
  localparam logic [2:0] CFG_ACTIVE_MARKER   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [9:0] RST_NUM_POINTS      = 10'd101;
  localparam logic       RST_SEARCH_GREATEST = 1'b0;
  localparam logic [7:0] RST_PICKUP_DISTANCE = 8'd20;
  localparam logic [1:0] RST_SELECTED_TRACE  = 2'd0;
  localparam logic [2:0] RST_ACTIVE_MARKER   = 3'd0;

  // Port widths
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int FOUND_W    = 9;

endpackage

[src/trace_extremum_marker_search_core.sv]
// Marker search engine over stored trace points.
//
// Input channel (in_*): one transaction per item. in_tuser holds the kind:
// load point, global extremum search, directional peak search or nearest
// point search. A load is written into the point memory at the handshake and
// produces no result. Every search produces exactly one result transaction.
// Result channel (out_*): out_tuser hit flag, tdata found index and marker slot.
// Configuration channel (cfg_*): register writes, always ready; write only
// while no search is in progress.
//
// Flow: a load leaves in_tready high, so the next item can follow at once. A
// global or directional search walks the point memory one entry per cycle
// through its single registered read port, over the n points in use (a
// directional one from its start entry); a nearest search squares dx and dy
// in turn on one multiplier, in S_EVAL and S_SQY, for each entry. in_tready
// stays low while a search runs and is high again in the cycle the result
// appears.
// A result waits in the output register until taken; a search that finishes
// behind a stalled result waits in its final state with in_tready low. Reset
// (synchronous) clears the sequencer, output valid flag and configuration only.
module trace_extremum_marker_search_core #(
  parameter int MAX_POINTS = 512,
  parameter int TRACES     = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tems_pkg::IN_DATA_W-1:0]       in_tdata,  // trace[1:0], index[10:2],
                                                          // coord_x[22:11], coord_y[34:23],
                                                          // search_backward[35], zero pad
  input  logic [tems_pkg::KIND_W-1:0]          in_tuser,  // kind[1:0]
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tems_pkg::OUT_DATA_W-1:0]      out_tdata, // found_index[8:0],
                                                          // marker_slot[11:9], zero pad
  output logic                                 out_tuser, // hit[0]
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tems_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tems_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SW    = CW + 1;
  localparam int DEPTH = TRACES * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PRW   = 2 * CB;
  localparam int LW    = 2 * CB + 1;
  localparam int FW    = tems_pkg::FOUND_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SQY   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // input fields
  logic [1:0]    f_trace;
  logic [8:0]    f_index;
  logic [CB-1:0] f_x;
  logic [CB-1:0] f_y;
  logic          f_back;
  logic          in_fire;

  assign f_trace = in_tdata[1:0];
  assign f_index = in_tdata[10:2];
  assign f_x     = CB'(in_tdata[22:11]);
  assign f_y     = CB'(in_tdata[34:23]);
  assign f_back  = in_tdata[35];

  // configuration registers
  logic [9:0] cfg_num_points_r;
  logic       cfg_greatest_r;
  logic [7:0] cfg_pickup_r;
  logic [1:0] cfg_sel_trace_r;
  logic [2:0] cfg_marker_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_points_r <= tems_pkg::RST_NUM_POINTS;
      cfg_greatest_r   <= tems_pkg::RST_SEARCH_GREATEST;
      cfg_pickup_r     <= tems_pkg::RST_PICKUP_DISTANCE;
      cfg_sel_trace_r  <= tems_pkg::RST_SELECTED_TRACE;
      cfg_marker_r     <= tems_pkg::RST_ACTIVE_MARKER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tems_pkg::CFG_NUM_POINTS:      cfg_num_points_r <= cfg_data;
        tems_pkg::CFG_SEARCH_GREATEST: cfg_greatest_r   <= cfg_data[0];
        tems_pkg::CFG_PICKUP_DISTANCE: cfg_pickup_r     <= cfg_data[7:0];
        tems_pkg::CFG_SELECTED_TRACE:  cfg_sel_trace_r  <= cfg_data[1:0];
        tems_pkg::CFG_ACTIVE_MARKER:   cfg_marker_r     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [1:0]    trace_r, trace_nxt;
  logic [8:0]    from_r, from_nxt;
  logic [CB-1:0] qx_r, qx_nxt;
  logic [CB-1:0] qy_r, qy_nxt;
  logic          back_r, back_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          first_r, first_nxt;
  logic          phase_r, phase_nxt;
  logic          hit_r, hit_nxt;
  logic [PW-1:0] best_r, best_nxt;
  logic [CB-1:0] value_r, value_nxt;
  logic [LW-1:0] limit_r, limit_nxt;
  logic [PRW-1:0] sq_r, sq_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [FW-1:0] out_found_r, out_found_nxt;
  logic [2:0]    out_marker_r, out_marker_nxt;

  // point memory, {x, y} per entry
  logic [2*CB-1:0] mem [DEPTH];
  logic [2*CB-1:0] rd_q;
  logic            rd_en;
  logic [PW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign wr_en   = in_fire && (in_tuser == tems_pkg::KIND_LOAD) &&
                   (32'(f_trace) < TRACES) && (32'(f_index) < MAX_POINTS);
  assign wr_addr = AW'(f_trace) * AW'(MAX_POINTS) + AW'(f_index);
  assign rd_addr = AW'(trace_r) * AW'(MAX_POINTS) + AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {f_x, f_y};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // true when b lies further toward the sought extreme than a
  function automatic logic beyond(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                  input logic greatest);
    beyond = greatest ? (a < b) : (a > b);
  endfunction

  logic [CB-1:0]  pt_x, pt_y;
  logic [CB:0]    diff_x, diff_y;
  logic [CB-1:0]  mag_x, mag_y;
  logic [CB-1:0]  mul_opnd;
  logic [PRW-1:0] mul_p;
  logic [LW-1:0]  dist_sq;
  logic [CW-1:0]  n_cur;
  logic           trace_ok;
  logic [SW-1:0]  step_idx;
  logic           step_ok;

  assign pt_x = rd_q[2*CB-1:CB];
  assign pt_y = rd_q[CB-1:0];

  // shared squaring unit: dx in S_EVAL, dy in S_SQY
  assign diff_x   = {1'b0, qx_r} - {1'b0, pt_x};
  assign diff_y   = {1'b0, qy_r} - {1'b0, pt_y};
  assign mag_x    = diff_x[CB] ? CB'(~diff_x + 1'b1) : diff_x[CB-1:0];
  assign mag_y    = diff_y[CB] ? CB'(~diff_y + 1'b1) : diff_y[CB-1:0];
  assign mul_opnd = (state_r == S_SQY) ? mag_y : mag_x;
  assign mul_p    = PRW'(mul_opnd) * PRW'(mul_opnd);
  assign dist_sq  = LW'(sq_r) + LW'(mul_p);

  assign n_cur    = (32'(cfg_num_points_r) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                         : CW'(cfg_num_points_r);
  assign trace_ok = (32'(trace_r) < TRACES);

  // next walk index; a step below zero wraps to a large value and fails the range check
  assign step_idx = back_r ? (idx_r - 1'b1) : (idx_r + 1'b1);
  assign step_ok  = (step_idx < SW'(n_r));

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    trace_nxt      = trace_r;
    from_nxt       = from_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    back_nxt       = back_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    phase_nxt      = phase_r;
    hit_nxt        = hit_r;
    best_nxt       = best_r;
    value_nxt      = value_r;
    limit_nxt      = limit_r;
    sq_nxt         = sq_r;
    rd_en          = 1'b0;
    rd_idx         = idx_r[PW-1:0];
    out_valid_nxt  = out_valid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_found_nxt  = out_found_r;
    out_marker_nxt = out_marker_r;

    unique case (state_r)
      S_IDLE: begin
        // capture a search; loads are handled by the memory write alone
        if (in_fire && (in_tuser != tems_pkg::KIND_LOAD)) begin
          kind_nxt  = in_tuser;
          trace_nxt = (in_tuser == tems_pkg::KIND_NEAREST) ? f_trace : cfg_sel_trace_r;
          from_nxt  = f_index;
          qx_nxt    = f_x;
          qy_nxt    = f_y;
          back_nxt  = (in_tuser == tems_pkg::KIND_DIR) && f_back;
          state_nxt = S_START;
        end
      end

      S_START: begin
        n_nxt     = n_cur;
        first_nxt = 1'b1;
        phase_nxt = 1'b0;
        hit_nxt   = 1'b0;
        best_nxt  = '0;
        limit_nxt = LW'(cfg_pickup_r) * LW'(cfg_pickup_r);
        idx_nxt   = '0;
        rd_idx    = '0;
        state_nxt = S_DONE;
        if (trace_ok) begin
          case (kind_r)
            tems_pkg::KIND_GLOBAL: begin
              // an empty sweep still reports index 0
              hit_nxt = 1'b1;
              if (n_cur != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            tems_pkg::KIND_DIR: begin
              if (32'(from_r) < MAX_POINTS) begin
                idx_nxt   = SW'(from_r);
                rd_idx    = PW'(from_r);
                rd_en     = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            default: begin
              if (n_cur != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_EVAL;
              end
            end
          endcase
        end
      end

      S_EVAL: begin
        case (kind_r)
          tems_pkg::KIND_NEAREST: begin
            sq_nxt    = mul_p;
            state_nxt = S_SQY;
          end
          tems_pkg::KIND_GLOBAL: begin
            if (first_r || beyond(value_r, pt_y, cfg_greatest_r)) begin
              value_nxt = pt_y;
              best_nxt  = idx_r[PW-1:0];
            end
            first_nxt = 1'b0;
          end
          default: begin
            // directional: climb away first, then follow the run toward the extreme
            value_nxt = pt_y;
            first_nxt = 1'b0;
            if (!first_r) begin
              if (!phase_r) begin
                if (beyond(value_r, pt_y, cfg_greatest_r)) begin
                  phase_nxt = 1'b1;
                  best_nxt  = idx_r[PW-1:0];
                  hit_nxt   = 1'b1;
                end
              end else if (beyond(pt_y, value_r, cfg_greatest_r)) begin
                value_nxt = value_r;
                state_nxt = S_DONE;
              end else begin
                best_nxt = idx_r[PW-1:0];
                hit_nxt  = 1'b1;
              end
            end
          end
        endcase
        // step to the next point unless the trend turned
        if ((kind_r != tems_pkg::KIND_NEAREST) && (state_nxt == S_EVAL)) begin
          if (step_ok) begin
            idx_nxt = step_idx;
            rd_idx  = step_idx[PW-1:0];
            rd_en   = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SQY: begin
        if (dist_sq < limit_r) begin
          limit_nxt = dist_sq;
          best_nxt  = idx_r[PW-1:0];
          hit_nxt   = 1'b1;
        end
        if (step_ok) begin
          idx_nxt   = step_idx;
          rd_idx    = step_idx[PW-1:0];
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = hit_r;
          out_found_nxt  = hit_r ? FW'(best_r) : '0;
          out_marker_nxt = cfg_marker_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    trace_r      <= trace_nxt;
    from_r       <= from_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    back_r       <= back_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    phase_r      <= phase_nxt;
    hit_r        <= hit_nxt;
    best_r       <= best_nxt;
    value_r      <= value_nxt;
    limit_r      <= limit_nxt;
    sq_r         <= sq_nxt;
    out_hit_r    <= out_hit_nxt;
    out_found_r  <= out_found_nxt;
    out_marker_r <= out_marker_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {4'b0, out_marker_r, out_found_r};

endmodule

[src/tems_checker.sv]
module tems_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tems_pkg::KIND_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tems_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             cfg_ready
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a miss reports index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[8:0] == '0)
    else $error("miss with non-zero index");

  // a search transaction makes the block busy
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != tems_pkg::KIND_LOAD) |=> !in_tready)
    else $error("ready during search");

  // a load leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == tems_pkg::KIND_LOAD) |=> in_tready)
    else $error("load blocked the input");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("bad state after reset");

endmodule

bind trace_extremum_marker_search_core tems_checker u_tems_checker (.*);

[tb/sv/tb_trace_extremum_marker_search_core.sv]
module tb_trace_extremum_marker_search_core;

  localparam int NPTS          = 512;
  localparam int NTRACE        = 4;
  localparam int CW            = 12;
  localparam int MAX_WAIT      = 14;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 2 * NPTS + 64;
  localparam int STALL_LIMIT   = 20000;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  trace;
    logic [8:0]  index;
    logic [11:0] cx;
    logic [11:0] cy;
    logic        backward;
  } point_req_t;

  typedef struct {
    logic       hit;
    logic [8:0] found;
    logic [2:0] slot;
  } marker_ans_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tems_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [tems_pkg::KIND_W-1:0]     in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tems_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [tems_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tems_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // shadow of the point memory and the registers
  logic [11:0] shadow_x [NTRACE][NPTS];
  logic [11:0] shadow_y [NTRACE][NPTS];
  bit          written  [NTRACE][NPTS];
  logic [9:0]  num_points_q = tems_pkg::RST_NUM_POINTS;
  logic        greatest_q   = tems_pkg::RST_SEARCH_GREATEST;
  logic [7:0]  pickup_q     = tems_pkg::RST_PICKUP_DISTANCE;
  logic [1:0]  trace_sel_q  = tems_pkg::RST_SELECTED_TRACE;
  logic [2:0]  marker_q     = tems_pkg::RST_ACTIVE_MARKER;

  marker_ans_t pending_answers[$];
  bit          stray_read;
  bit          calm           = 1'b0;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          ready_hold     = 1;
  int          wave_y         = 2048;
  int          wave_dir       = 1;
  int          wave_run       = 0;

  trace_extremum_marker_search_core #(
    .MAX_POINTS(NPTS),
    .TRACES    (NTRACE),
    .COORD_BITS(CW)
  ) uut (.*);

  always #5 clk = ~clk;

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int points_in_use();
    return (num_points_q > NPTS) ? NPTS : int'(num_points_q);
  endfunction

  // y read that flags entries never loaded
  function automatic logic [11:0] stored_y(int tr, int i);
    if (!written[tr][i]) stray_read = 1'b1;
    return shadow_y[tr][i];
  endfunction

  // b lies further toward the sought extreme than a
  function automatic bit further(logic [11:0] a, logic [11:0] b);
    return greatest_q ? (a < b) : (a > b);
  endfunction

  function automatic marker_ans_t marker_search_answer(point_req_t rq);
    marker_ans_t ans;
    int          n, i, step, best, tr, dx, dy, d, lim;
    logic [11:0] v, y;
    n       = points_in_use();
    ans.hit = 1'b0;
    best    = 0;
    case (rq.kind)
      tems_pkg::KIND_GLOBAL: begin
        tr = trace_sel_q;
        v  = stored_y(tr, 0);
        for (i = 1; i < n; i++) begin
          y = stored_y(tr, i);
          if (further(v, y)) begin
            v    = y;
            best = i;
          end
        end
        ans.hit = 1'b1;
      end
      tems_pkg::KIND_DIR: begin
        tr   = trace_sel_q;
        step = rq.backward ? -1 : 1;
        best = -1;
        v    = stored_y(tr, rq.index);
        i    = int'(rq.index) + step;
        // climb away from the target first
        while (i >= 0 && i < n) begin
          y = stored_y(tr, i);
          if (further(v, y)) break;
          v = y;
          i += step;
        end
        // then follow the run toward it
        while (i >= 0 && i < n) begin
          y = stored_y(tr, i);
          if (further(y, v)) break;
          v    = y;
          best = i;
          i += step;
        end
        ans.hit = (best >= 0);
      end
      tems_pkg::KIND_NEAREST: begin
        tr  = rq.trace;
        lim = int'(pickup_q) * int'(pickup_q);
        for (i = 0; i < n; i++) begin
          dx = int'(rq.cx) - int'(shadow_x[tr][i]);
          dy = int'(rq.cy) - int'(stored_y(tr, i));
          d  = dx * dx + dy * dy;
          if (d < lim) begin
            lim     = d;
            best    = i;
            ans.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    ans.found = ans.hit ? best[8:0] : 9'd0;
    ans.slot  = marker_q;
    return ans;
  endfunction

  function automatic bit reads_written(point_req_t rq);
    marker_ans_t dummy;
    stray_read = 1'b0;
    dummy      = marker_search_answer(rq);
    return !stray_read;
  endfunction

  function automatic point_req_t make_req(logic [1:0] kind, logic [1:0] tr, logic [8:0] idx,
                                          logic [11:0] x, logic [11:0] y, logic back);
    point_req_t rq;
    rq.kind     = kind;
    rq.trace    = tr;
    rq.index    = idx;
    rq.cx       = x;
    rq.cy       = y;
    rq.backward = back;
    return rq;
  endfunction

  // piecewise ramp with random run lengths: gives peaks, valleys and plateaus
  function automatic logic [11:0] next_wave_y();
    int stepv;
    if (wave_run == 0) begin
      wave_dir = -wave_dir;
      wave_run = $urandom_range(1, 9);
    end
    wave_run--;
    stepv  = $urandom_range(0, 400);
    wave_y += wave_dir * stepv;
    if (wave_y < 0) wave_y = 0;
    if (wave_y > 4095) wave_y = 4095;
    return wave_y[11:0];
  endfunction

  // coordinate within about one pickup radius of v
  function automatic logic [11:0] jitter(logic [11:0] v);
    int r, o;
    r = int'(pickup_q) + 1;
    o = int'(v) + int'($urandom_range(0, 2 * r)) - r;
    if (o < 0) o = 0;
    if (o > 4095) o = 4095;
    return o[11:0];
  endfunction

  function automatic point_req_t random_req();
    point_req_t rq;
    int         n, pick, i;
    n    = points_in_use();
    rq   = make_req(tems_pkg::KIND_LOAD, 2'($urandom), 9'($urandom), 12'($urandom),
                    12'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if (n > 0 && pick < 11) rq.index = 9'($urandom_range(0, n - 1));
      if (pick < 8) rq.cy = next_wave_y();
    end else if (pick < 40) begin
      rq.kind = tems_pkg::KIND_GLOBAL;
    end else if (pick < 75) begin
      rq.kind = tems_pkg::KIND_DIR;
      if (n > 0 && pick < 70) rq.index = 9'($urandom_range(0, n - 1));
    end else begin
      rq.kind = tems_pkg::KIND_NEAREST;
      if (n > 0 && pick < 95) begin
        if ($urandom_range(0, 2) != 0) rq.trace = trace_sel_q;
        i = $urandom_range(0, n - 1);
        if (written[rq.trace][i]) begin
          rq.cx = jitter(shadow_x[rq.trace][i]);
          rq.cy = jitter(shadow_y[rq.trace][i]);
        end
      end
    end
    return rq;
  endfunction

  // a search that would touch an unloaded entry becomes a load of that entry
  function automatic point_req_t fill_gap(point_req_t rq);
    int tr, n, i, target;
    tr     = (rq.kind == tems_pkg::KIND_NEAREST) ? int'(rq.trace) : int'(trace_sel_q);
    n      = points_in_use();
    target = (rq.kind == tems_pkg::KIND_DIR) ? int'(rq.index) : 0;
    for (i = n - 1; i >= 0; i--)
      if (!written[tr][i]) target = i;
    return make_req(tems_pkg::KIND_LOAD, tr[1:0], target[8:0], 12'($urandom), next_wave_y(),
                    1'($urandom));
  endfunction

  // one input transaction, preceded by a random gap
  task automatic send_item(input point_req_t rq);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (rq.kind != tems_pkg::KIND_LOAD) pending_answers.push_back(marker_search_answer(rq));
    in_tvalid <= 1'b1;
    in_tuser  <= rq.kind;
    in_tdata  <= {4'd0, rq.backward, rq.cy, rq.cx, rq.index, rq.trace};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (rq.kind == tems_pkg::KIND_LOAD) begin
      shadow_x[rq.trace][rq.index] = rq.cx;
      shadow_y[rq.trace][rq.index] = rq.cy;
      written[rq.trace][rq.index]  = 1'b1;
    end
  endtask

  // hold off the sender until every search has answered
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all five registers back to back; narrow ones get junk upper bits
  task automatic apply_settings(input logic [9:0] np, input logic gr, input logic [7:0] pd,
                                input logic [1:0] ts, input logic [2:0] mk);
    logic [9:0] junk;
    logic [9:0] vals [5];
    logic [2:0] regs [5];
    settle();
    junk    = 10'($urandom);
    regs    = '{tems_pkg::CFG_NUM_POINTS, tems_pkg::CFG_SEARCH_GREATEST,
                tems_pkg::CFG_PICKUP_DISTANCE, tems_pkg::CFG_SELECTED_TRACE,
                tems_pkg::CFG_ACTIVE_MARKER};
    vals[0] = np;
    vals[1] = {junk[9:1], gr};
    vals[2] = {junk[9:8], pd};
    vals[3] = {junk[9:2], ts};
    vals[4] = {junk[9:3], mk};
    for (int r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid    <= 1'b0;
    num_points_q = np;
    greatest_q   = gr;
    pickup_q     = pd;
    trace_sel_q  = ts;
    marker_q     = mk;
  endtask

  task automatic fill_trace(input int tr, input int count);
    for (int i = 0; i < count; i++)
      if (!written[tr][i])
        send_item(make_req(tems_pkg::KIND_LOAD, tr[1:0], i[8:0], 12'($urandom),
                           next_wave_y(), 1'($urandom)));
  endtask

  task automatic random_items(input int count);
    point_req_t rq;
    for (int k = 0; k < count; k++) begin
      rq = random_req();
      if (rq.kind != tems_pkg::KIND_LOAD && !reads_written(rq)) rq = fill_gap(rq);
      if ($urandom_range(0, 39) == 0) settle();
      send_item(rq);
    end
  endtask

  // field extremes, every kind, empty sweep, out-of-range start, zero radius
  task automatic test_directed_cases();
    apply_settings(10'd4, 1'b0, 8'd20, 2'd0, 3'd7);
    send_item(make_req(tems_pkg::KIND_LOAD, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_LOAD, 2'd0, 9'd1, 12'hFFF, 12'hFFF, 1'b1));
    send_item(make_req(tems_pkg::KIND_LOAD, 2'd0, 9'd2, 12'hAAA, 12'h555, 1'b0));
    send_item(make_req(tems_pkg::KIND_LOAD, 2'd0, 9'd3, 12'h555, 12'hAAA, 1'b1));
    send_item(make_req(tems_pkg::KIND_LOAD, 2'd3, 9'd511, 12'hFFF, 12'hFFF, 1'b1));
    send_item(make_req(tems_pkg::KIND_GLOBAL, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd3, 12'h000, 12'h000, 1'b1));
    send_item(make_req(tems_pkg::KIND_NEAREST, 2'd0, 9'd0, 12'hFFF, 12'hFFF, 1'b0));
    send_item(make_req(tems_pkg::KIND_NEAREST, 2'd0, 9'd0, 12'h800, 12'h800, 1'b0));
    // greatest y, widest radius
    apply_settings(10'd4, 1'b1, 8'd255, 2'd0, 3'd0);
    send_item(make_req(tems_pkg::KIND_GLOBAL, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd2, 12'h000, 12'h000, 1'b1));
    send_item(make_req(tems_pkg::KIND_NEAREST, 2'd0, 9'd0, 12'h5B9, 12'hAAA, 1'b0));
    // start beyond the sweep, zero radius never accepts
    apply_settings(10'd4, 1'b0, 8'd0, 2'd3, 3'd5);
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd511, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd511, 12'h000, 12'h000, 1'b1));
    send_item(make_req(tems_pkg::KIND_NEAREST, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    // empty sweep
    apply_settings(10'd0, 1'b0, 8'd20, 2'd0, 3'd2);
    send_item(make_req(tems_pkg::KIND_GLOBAL, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd1, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_NEAREST, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    // single point
    apply_settings(10'd1, 1'b1, 8'd20, 2'd0, 3'd1);
    send_item(make_req(tems_pkg::KIND_GLOBAL, 2'd0, 9'd0, 12'h000, 12'h000, 1'b0));
    send_item(make_req(tems_pkg::KIND_DIR, 2'd0, 9'd0, 12'h000, 12'h000, 1'b1));
  endtask

  // whole trace loaded, full sweep and an oversized point count
  task automatic test_full_sweep();
    apply_settings(10'd512, 1'b0, 8'd255, 2'd2, 3'd3);
    calm = 1'b1;
    fill_trace(2, 256);
    calm = 1'b0;
    fill_trace(2, NPTS);
    random_items(12);
    apply_settings(10'd1023, 1'b1, 8'd8, 2'd2, 3'd6);
    random_items(12);
  endtask

  // phases of random traffic, each under its own register setting
  task automatic test_random_phases();
    logic [9:0] np;
    logic [7:0] pd;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       np = 10'd1;
        1:       np = 10'd2;
        6:       np = 10'd0;
        8:       np = 10'($urandom_range(300, 512));
        default: np = 10'($urandom_range(3, 48));
      endcase
      case (p)
        0:       pd = 8'd0;
        1:       pd = 8'd255;
        default: pd = 8'($urandom);
      endcase
      calm = (p == 3) || (p == 7);
      apply_settings(np, 1'($urandom), pd, (p == 8) ? 2'd2 : 2'($urandom), 3'($urandom));
      fill_trace(int'(trace_sel_q), points_in_use());
      random_items(25);
    end
    calm = 1'b0;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 1;
    end else if (out_tready && out_tvalid) begin
      ready_hold <= draw_wait();
      if (ready_hold != 0 && $urandom_range(0, 3) != 0) out_tready <= 1'b0;
    end else if (!out_tready) begin
      if (ready_hold <= 1) out_tready <= 1'b1;
      else ready_hold <= ready_hold - 1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    marker_ans_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result hit=%0b found_index=%0d marker_slot=%0d",
                 $time, out_tuser, out_tdata[8:0], out_tdata[11:9]);
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.hit) begin
          mismatch_count++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_tuser);
        end
        if (out_tdata[8:0] !== want.found) begin
          mismatch_count++;
          $display("%0t: found_index expected %0d actual %0d",
                   $time, want.found, out_tdata[8:0]);
        end
        if (out_tdata[11:9] !== want.slot) begin
          mismatch_count++;
          $display("%0t: marker_slot expected %0d actual %0d",
                   $time, want.slot, out_tdata[11:9]);
        end
      end
    end
  end

  // cycles without any transaction on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_sweep();
    test_random_phases();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
